@@ rtl/pva_pkg.sv @@
// Shared constants, codes and types of the polyphonic voice allocator.
// Depends on nothing; pva_ctrl and the top level refer to it by scoped names.
`default_nettype none

package pva_pkg;

	localparam int VOICES = 8;
	localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int AGE_W  = $clog2(VOICES + 1);

	localparam int NOTE_W = 7;
	localparam int VEL_W  = 7;
	localparam int ACT_W  = 3;
	localparam int VOUT_W = 3;

	localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(VOICES - 1);
	localparam logic [AGE_W-1:0]  AGE_NEWEST_FULL = AGE_W'(VOICES - 1);

	localparam logic CMD_ON  = 1'b0;
	localparam logic CMD_OFF = 1'b1;

	localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_START   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_STEAL   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_RETRIG  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd4;

	typedef struct packed {
		logic [NOTE_W-1:0] note;
		logic [AGE_W-1:0]  age;
	} pva_entry_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [VOUT_W-1:0] voice_index;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  velocity;
	} pva_result_t;

	typedef struct packed {
		logic              we;
		logic [VIDX_W-1:0] waddr;
		pva_entry_t        wdata;
		logic              re;
		logic [VIDX_W-1:0] raddr;
	} pva_ram_req_t;

endpackage

`default_nettype wire

@@ rtl/pva_ram.sv @@
// Simple dual-port synchronous RAM: one write and one registered read per cycle.
// Generic; holds the per-voice note and age entries of the allocator.
`default_nettype none

module pva_ram #(
	parameter int DW    = 8,
	parameter int AW    = 3,
	parameter int DEPTH = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/pva_ctrl.sv @@
// Event sequencer: scans the voice RAM, decides the action and runs the age fix-up pass.
// Depends on pva_pkg; drives the voice RAM and hands one result to the output register.
`default_nettype none

module pva_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     in_cmd,
	input  wire logic [pva_pkg::NOTE_W-1:0] in_note,
	input  wire logic [pva_pkg::VEL_W-1:0]  in_vel,
	output pva_pkg::pva_ram_req_t         ram_req,
	input  pva_pkg::pva_entry_t           ram_rdata,
	output logic                          res_valid,
	input  wire logic                     res_ready,
	output pva_pkg::pva_result_t          res
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_FIX    = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	logic [2:0]                     state_q;
	logic [pva_pkg::VOICES-1:0]     active_q;
	logic [pva_pkg::AGE_W-1:0]      next_age_q;
	logic [pva_pkg::VIDX_W-1:0]     rcnt_q;
	logic                           iss_q;
	logic                           rd_v_s1;
	logic [pva_pkg::VIDX_W-1:0]     idx_s1;
	logic                           found_q;
	logic                           free_q;
	logic                           steal_q;

	// Event payload and scan results.
	logic                           cmd_q;
	logic [pva_pkg::NOTE_W-1:0]     note_q;
	logic [pva_pkg::VEL_W-1:0]      vel_q;
	logic [pva_pkg::VIDX_W-1:0]     mt_idx_q;
	logic [pva_pkg::AGE_W-1:0]      mt_age_q;
	logic [pva_pkg::VIDX_W-1:0]     free_idx_q;
	logic [pva_pkg::VIDX_W-1:0]     old_idx_q;
	pva_pkg::pva_result_t           res_q;
	pva_pkg::pva_result_t           res_d;

	logic accept;
	logic note_on;
	logic last_s1;
	logic act_s1;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign note_on   = (cmd_q == pva_pkg::CMD_ON) && (vel_q != '0);
	assign last_s1   = rd_v_s1 && (idx_s1 == pva_pkg::LAST_IDX);
	assign act_s1    = active_q[idx_s1];
	assign res_valid = (state_q == ST_OUT);
	assign res       = res_q;

	// RAM port: reads walk the table during scan and fix-up; writes come from decide and fix-up.
	always_comb begin
		ram_req       = '0;
		ram_req.re    = iss_q;
		ram_req.raddr = rcnt_q;
		if (state_q == ST_DECIDE && note_on && !found_q && free_q) begin
			ram_req.we          = 1'b1;
			ram_req.waddr       = free_idx_q;
			ram_req.wdata.note  = note_q;
			ram_req.wdata.age   = next_age_q;
		end else if (state_q == ST_FIX && rd_v_s1) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = idx_s1;
			ram_req.wdata = ram_rdata;
			if (steal_q) begin
				if (idx_s1 == old_idx_q) begin
					ram_req.wdata.note = note_q;
					ram_req.wdata.age  = pva_pkg::AGE_NEWEST_FULL;
				end else begin
					ram_req.wdata.age = ram_rdata.age - pva_pkg::AGE_W'(1);
				end
			end else if (act_s1 && (ram_rdata.age > mt_age_q)) begin
				ram_req.wdata.age = ram_rdata.age - pva_pkg::AGE_W'(1);
			end
		end
	end

	// Result of the event, taken into the result register in the decision cycle.
	always_comb begin
		res_d          = '0;
		res_d.note     = note_q;
		res_d.velocity = vel_q;
		if (note_on) begin
			if (found_q) begin
				res_d.action      = pva_pkg::ACT_RETRIG;
				res_d.voice_index = pva_pkg::VOUT_W'(mt_idx_q);
			end else if (free_q) begin
				res_d.action      = pva_pkg::ACT_START;
				res_d.voice_index = pva_pkg::VOUT_W'(free_idx_q);
			end else begin
				res_d.action      = pva_pkg::ACT_STEAL;
				res_d.voice_index = pva_pkg::VOUT_W'(old_idx_q);
			end
		end else if (found_q) begin
			res_d.action      = pva_pkg::ACT_RELEASE;
			res_d.voice_index = pva_pkg::VOUT_W'(mt_idx_q);
		end else begin
			res_d.note     = '0;
			res_d.velocity = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			active_q   <= '0;
			next_age_q <= '0;
			rcnt_q     <= '0;
			iss_q      <= 1'b0;
			rd_v_s1    <= 1'b0;
			idx_s1     <= '0;
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			steal_q    <= 1'b0;
		end else begin
			rd_v_s1 <= iss_q;
			idx_s1  <= rcnt_q;
			if (iss_q) begin
				if (rcnt_q == pva_pkg::LAST_IDX) begin
					iss_q <= 1'b0;
				end else begin
					rcnt_q <= rcnt_q + pva_pkg::VIDX_W'(1);
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						rcnt_q  <= '0;
						iss_q   <= 1'b1;
						found_q <= 1'b0;
						free_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (rd_v_s1) begin
						if (act_s1 && ram_rdata.note == note_q && !found_q) begin
							found_q <= 1'b1;
						end
						if (!act_s1 && !free_q) begin
							free_q <= 1'b1;
						end
					end
					if (last_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (note_on) begin
						if (found_q) begin
							state_q <= ST_OUT;
						end else if (free_q) begin
							active_q[free_idx_q] <= 1'b1;
							next_age_q <= next_age_q + pva_pkg::AGE_W'(1);
							state_q <= ST_OUT;
						end else begin
							steal_q <= 1'b1;
							rcnt_q  <= '0;
							iss_q   <= 1'b1;
							state_q <= ST_FIX;
						end
					end else if (found_q) begin
						active_q[mt_idx_q] <= 1'b0;
						next_age_q <= next_age_q - pva_pkg::AGE_W'(1);
						steal_q <= 1'b0;
						rcnt_q  <= '0;
						iss_q   <= 1'b1;
						state_q <= ST_FIX;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_FIX: begin
					if (last_s1) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= in_cmd;
			note_q <= in_note;
			vel_q  <= in_vel;
		end
		if (state_q == ST_SCAN && rd_v_s1) begin
			if (act_s1 && ram_rdata.note == note_q && !found_q) begin
				mt_idx_q <= idx_s1;
				mt_age_q <= ram_rdata.age;
			end
			if (!act_s1 && !free_q) begin
				free_idx_q <= idx_s1;
			end
			// With every voice busy the ages are a permutation, so the oldest holds age zero.
			if (act_s1 && ram_rdata.age == '0) begin
				old_idx_q <= idx_s1;
			end
		end
		if (state_q == ST_DECIDE) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/poly_voice_allocator_oldest_steal_top.sv @@
// Top level of the polyphonic voice allocator with oldest-note stealing.
// Depends on pva_pkg, pva_ram and pva_ctrl; adds the result output register.
//
// Usage:
//   The slave channel takes one MIDI event per request: s_tuser is the command
//   (note on or note off) and s_tdata carries note and velocity. A note-on with
//   velocity zero counts as a note-off. Every event yields exactly one result
//   request on the master channel: m_tuser is the action code and m_tdata holds
//   the voice index, note and velocity passed on to that voice.
//   The voice table (note and age rank) lives in a one-port-read, one-port-write
//   RAM with a registered read; the active flags and the next-age count sit in
//   flip-flops. Each event is one scan pass over the RAM, one voice per cycle,
//   then a decision cycle. Retrigger, free-voice start and ignored note-off
//   finish there. Steal and release add a read-modify-write pass that renumbers
//   the ages. One event is in work at a time; s_tready is high only while the
//   sequencer is idle, so a new event is taken only after the last one has
//   handed its result to the output register. A finished result waits in the
//   output register, and the next event is already accepted while it waits; a
//   stalled receiver holds back a second result only. Reset clears all voices
//   to silent and the next age to zero.
`default_nettype none

module poly_voice_allocator_oldest_steal_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // note [6:0], velocity [13:7], zero [15:14]
	input  wire logic        s_tuser,   // command [0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // voice_index [2:0], out_note [9:3],
	                                    // out_velocity [16:10], zero [23:17]
	output logic      [2:0]  m_tuser    // action [2:0]
);

	pva_pkg::pva_ram_req_t ram_req;
	pva_pkg::pva_entry_t   ram_rdata;
	pva_pkg::pva_result_t  res;
	logic                  res_valid;
	logic                  res_ready;

	logic                  m_tvalid_q;
	pva_pkg::pva_result_t  m_res_q;

	pva_ram #(
		.DW    ($bits(pva_pkg::pva_entry_t)),
		.AW    (pva_pkg::VIDX_W),
		.DEPTH (pva_pkg::VOICES)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	pva_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_note   (s_tdata[6:0]),
		.in_vel    (s_tdata[13:7]),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// The output register takes a new result whenever it is empty or being drained.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_res_q.action;
	assign m_tdata  = {7'd0, m_res_q.velocity, m_res_q.note, m_res_q.voice_index};

endmodule

`default_nettype wire
